@@ design/s1_s2_stimulus_pulse_train_assert.svh @@
// assertion macros shared by the pulse train modules
`ifndef S1_S2_STIMULUS_PULSE_TRAIN_ASSERT_SVH
`define S1_S2_STIMULUS_PULSE_TRAIN_ASSERT_SVH
// property that must hold at every clock edge out of reset
`define SPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// property that must hold after the trigger, as a non-overlapping implication
`define SPT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

@@ design/spt_pkg.sv @@
// shared widths, register indexes, train codes and types of the pulse train
package spt_pkg;

  localparam int unsigned DEF_TIME_BITS = 32;
  localparam int unsigned START_W       = 32;
  localparam int unsigned PER_W         = 24;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned SPAN_W        = PER_W + CNT_W;
  localparam int unsigned AMP_W         = 16;
  localparam int unsigned ID_W          = 2;
  localparam int unsigned CFG_AW        = 3;
  localparam int unsigned CFG_DW        = 32;
  localparam int unsigned OUT_TDATA_W   = ((AMP_W + ID_W + 7) / 8) * 8;

  typedef logic [CFG_AW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_START_TIME  = 3'd0;
  localparam cfg_idx_t REG_S1_PERIOD   = 3'd1;
  localparam cfg_idx_t REG_S1_COUNT    = 3'd2;
  localparam cfg_idx_t REG_S2_PERIOD   = 3'd3;
  localparam cfg_idx_t REG_S2_COUNT    = 3'd4;
  localparam cfg_idx_t REG_PULSE_WIDTH = 3'd5;
  localparam cfg_idx_t REG_AMPLITUDE   = 3'd6;

  typedef logic [ID_W-1:0] train_id_t;

  // train codes on the result beat
  localparam train_id_t ID_NONE = 2'd0;
  localparam train_id_t ID_S1   = 2'd1;
  localparam train_id_t ID_S2   = 2'd2;

  localparam logic signed [AMP_W-1:0] AMP_MIN = 16'sh8000;
  localparam logic signed [AMP_W-1:0] AMP_MAX = 16'sh7fff;

  // control that travels with each beat down the pipeline
  typedef struct packed {
    logic vld;
    logic win1;
    logic win2;
  } ctl_t;

endpackage

@@ design/spt_front.sv @@
// window front end: span products, offsets into both trains and window flags
module spt_front #(
  parameter int unsigned TIME_BITS = spt_pkg::DEF_TIME_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 in_vld_i,
  input  logic [TIME_BITS-1:0]                 time_i,
  input  logic [spt_pkg::START_W-1:0]          start_time_i,
  input  logic [spt_pkg::PER_W-1:0]            s1_period_i,
  input  logic [spt_pkg::CNT_W-1:0]            s1_count_i,
  input  logic [spt_pkg::PER_W-1:0]            s2_period_i,
  input  logic [spt_pkg::CNT_W-1:0]            s2_count_i,
  output spt_pkg::ctl_t                        ctl_o,
  output logic [1:0][TIME_BITS-1:0]            dvd_o
);

  localparam int unsigned SPAN_W = spt_pkg::SPAN_W;
  localparam int unsigned D_W    = ((TIME_BITS > SPAN_W) ? TIME_BITS : SPAN_W) + 1;

  logic [2:0]              vld_q;
  logic [TIME_BITS-1:0]    t0_q;
  logic [SPAN_W-1:0]       sp1_0_q, sp2_0_q;
  logic [TIME_BITS:0]      since1_1_q;
  logic [SPAN_W-1:0]       sp1_1_q, sp2_1_q;
  logic [TIME_BITS-1:0]    since1_2_q;
  logic [D_W-1:0]          d2_q;
  logic                    win1_2_q, ge2_2_q;
  logic [SPAN_W-1:0]       sp2_2_q;
  spt_pkg::ctl_t           ctl_q;
  logic [1:0][TIME_BITS-1:0] dvd_q;

  logic                    s1_en, s2_en;
  logic [TIME_BITS-1:0]    base1;
  logic [D_W-1:0]          d2_d;
  logic                    win1_d, ge2_d, win2_d;

  // a train with zero period or zero count never pulses
  assign s1_en = (s1_period_i != '0) && (s1_count_i != '0);
  assign s2_en = (s2_period_i != '0) && (s2_count_i != '0);
  assign base1 = TIME_BITS'(start_time_i);

  // offset past the end of the S1 span, negative while still inside it
  assign d2_d   = D_W'(since1_1_q[TIME_BITS-1:0]) - D_W'(sp1_1_q);
  assign win1_d = s1_en && !since1_1_q[TIME_BITS] && (d2_d[D_W-1] || (d2_d == '0));
  assign ge2_d  = !since1_1_q[TIME_BITS] && !d2_d[D_W-1];
  assign win2_d = s2_en && ge2_2_q && (d2_q[D_W-2:0] <= (D_W-1)'(sp2_2_q));

  // beat valids and window flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ctl_q <= '0;
    end else if (en_i) begin
      vld_q      <= {vld_q[1:0], in_vld_i};
      ctl_q.vld  <= vld_q[2];
      ctl_q.win1 <= win1_2_q;
      ctl_q.win2 <= win2_d;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q       <= time_i;
      sp1_0_q    <= SPAN_W'(s1_period_i) * SPAN_W'(s1_count_i);
      sp2_0_q    <= SPAN_W'(s2_period_i) * SPAN_W'(s2_count_i);
      since1_1_q <= {1'b0, t0_q} - {1'b0, base1};
      sp1_1_q    <= sp1_0_q;
      sp2_1_q    <= sp2_0_q;
      since1_2_q <= since1_1_q[TIME_BITS-1:0];
      d2_q       <= d2_d;
      win1_2_q   <= win1_d;
      ge2_2_q    <= ge2_d;
      sp2_2_q    <= sp2_1_q;
      dvd_q[0]   <= since1_2_q;
      dvd_q[1]   <= d2_q[TIME_BITS-1:0];
    end
  end

  assign ctl_o = ctl_q;
  assign dvd_o = dvd_q;

endmodule

@@ design/spt_mod_cell.sv @@
// one restoring remainder step for the S1 and S2 lanes
`include "s1_s2_stimulus_pulse_train_assert.svh"

module spt_mod_cell #(
  parameter int unsigned TIME_BITS = spt_pkg::DEF_TIME_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  spt_pkg::ctl_t                     ctl_i,
  input  logic [1:0][spt_pkg::PER_W-1:0]    rem_i,
  input  logic [1:0][TIME_BITS-1:0]         dvd_i,
  input  logic [1:0][spt_pkg::PER_W-1:0]    period_i,
  output spt_pkg::ctl_t                     ctl_o,
  output logic [1:0][spt_pkg::PER_W-1:0]    rem_o,
  output logic [1:0][TIME_BITS-1:0]         dvd_o
);

  localparam int unsigned PER_W = spt_pkg::PER_W;

  spt_pkg::ctl_t                 ctl_q;
  logic [1:0][PER_W-1:0]         rem_q, rem_d;
  logic [1:0][TIME_BITS-1:0]     dvd_q;
  logic [1:0][PER_W:0]           part;

  // bring in the next dividend bit and subtract the period when it fits
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      part[l] = {rem_i[l], dvd_i[l][TIME_BITS-1]};
      if (part[l] >= {1'b0, period_i[l]}) begin
        rem_d[l] = PER_W'(part[l] - {1'b0, period_i[l]});
      end else begin
        rem_d[l] = part[l][PER_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      for (int l = 0; l < 2; l++) begin
        dvd_q[l] <= {dvd_i[l][TIME_BITS-2:0], 1'b0};
      end
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign dvd_o = dvd_q;

  // remainders stay below the period on every lane inside its window
  `SPT_ASSERT_NEXT(a_rem1_below_period, en_i && ctl_i.vld && ctl_i.win1, rem_o[0] < period_i[0], "S1 remainder reached the period")
  `SPT_ASSERT_NEXT(a_rem2_below_period, en_i && ctl_i.vld && ctl_i.win2, rem_o[1] < period_i[1], "S2 remainder reached the period")

endmodule

@@ design/s1_s2_stimulus_pulse_train.sv @@
// top level of the two-phase S1/S2 pacing stimulus generator
//
// Each input beat on s_axis carries one time stamp; each output beat on
// m_axis carries the stimulus at that time and the train that produced it.
// The S1 train starts at start_time and spans s1_period * s1_count ticks,
// the S2 train follows for s2_period * s2_count ticks. A pulse is on while
// the phase within the period is at most pulse_width; it gives -amplitude,
// saturated to the positive limit, otherwise the stimulus is zero.
// Registers are written over the cfg channel, which is always ready; write
// them only while no beat is in flight.
// An accepted input beat passes through four front stages, one remainder cell
// per time bit, and the output register to become its output beat. One beat is
// accepted every cycle unless the output beat waits on m_axis_tready.
// The whole pipeline moves as one: while the output beat waits on
// m_axis_tready, s_axis_tready is low and every stage holds.
// Reset clears the configuration registers and valid flags and empties the pipeline.
`include "s1_s2_stimulus_pulse_train_assert.svh"

module s1_s2_stimulus_pulse_train #(
  parameter int unsigned TIME_BITS = spt_pkg::DEF_TIME_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // time_now [TIME_BITS-1:0], zero filled to whole bytes
  input  logic [((TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // stimulus [15:0], train_id [17:16], zero filled to 24 bits
  output logic [spt_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  spt_pkg::cfg_idx_t                      cfg_addr_i,
  input  logic [spt_pkg::CFG_DW-1:0]             cfg_data_i
);

  localparam int unsigned PER_W = spt_pkg::PER_W;
  localparam int unsigned CNT_W = spt_pkg::CNT_W;
  localparam int unsigned AMP_W = spt_pkg::AMP_W;

  logic [spt_pkg::START_W-1:0]   start_time_q;
  logic [PER_W-1:0]              s1_period_q, s2_period_q, pulse_width_q;
  logic [CNT_W-1:0]              s1_count_q, s2_count_q;
  logic signed [AMP_W-1:0]       amplitude_q;

  logic                          en;
  logic                          out_vld_q;
  logic signed [AMP_W-1:0]       stim_q, stim_d, amp_neg;
  spt_pkg::train_id_t            id_q, id_d;
  logic [1:0][PER_W-1:0]         period;

  spt_pkg::ctl_t                 chain_ctl [TIME_BITS+1];
  logic [1:0][PER_W-1:0]         chain_rem [TIME_BITS+1];
  logic [1:0][TIME_BITS-1:0]     chain_dvd [TIME_BITS+1];

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q  <= '0;
      s1_period_q   <= '0;
      s1_count_q    <= '0;
      s2_period_q   <= '0;
      s2_count_q    <= '0;
      pulse_width_q <= '0;
      amplitude_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        spt_pkg::REG_START_TIME:  start_time_q  <= cfg_data_i;
        spt_pkg::REG_S1_PERIOD:   s1_period_q   <= cfg_data_i[PER_W-1:0];
        spt_pkg::REG_S1_COUNT:    s1_count_q    <= cfg_data_i[CNT_W-1:0];
        spt_pkg::REG_S2_PERIOD:   s2_period_q   <= cfg_data_i[PER_W-1:0];
        spt_pkg::REG_S2_COUNT:    s2_count_q    <= cfg_data_i[CNT_W-1:0];
        spt_pkg::REG_PULSE_WIDTH: pulse_width_q <= cfg_data_i[PER_W-1:0];
        spt_pkg::REG_AMPLITUDE:   amplitude_q   <= cfg_data_i[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipeline advances whenever the output register is free or drains
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign period[0] = s1_period_q;
  assign period[1] = s2_period_q;

  spt_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_vld_i     (s_axis_tvalid_i),
    .time_i       (s_axis_tdata_i[TIME_BITS-1:0]),
    .start_time_i (start_time_q),
    .s1_period_i  (s1_period_q),
    .s1_count_i   (s1_count_q),
    .s2_period_i  (s2_period_q),
    .s2_count_i   (s2_count_q),
    .ctl_o        (chain_ctl[0]),
    .dvd_o        (chain_dvd[0])
  );

  assign chain_rem[0] = '0;

  // remainder chain, one dividend bit per cell, MSB first
  for (genvar k = 0; k < TIME_BITS; k++) begin : g_cell
    spt_mod_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctl_i    (chain_ctl[k]),
      .rem_i    (chain_rem[k]),
      .dvd_i    (chain_dvd[k]),
      .period_i (period),
      .ctl_o    (chain_ctl[k+1]),
      .rem_o    (chain_rem[k+1]),
      .dvd_o    (chain_dvd[k+1])
    );
  end

  // phase test, S1 first, and saturating negation
  assign amp_neg = (amplitude_q == spt_pkg::AMP_MIN) ? spt_pkg::AMP_MAX : -amplitude_q;

  always_comb begin
    id_d = spt_pkg::ID_NONE;
    if (chain_ctl[TIME_BITS].win1 && (chain_rem[TIME_BITS][0] <= pulse_width_q)) begin
      id_d = spt_pkg::ID_S1;
    end else if (chain_ctl[TIME_BITS].win2 &&
                 (chain_rem[TIME_BITS][1] <= pulse_width_q)) begin
      id_d = spt_pkg::ID_S2;
    end
    stim_d = (id_d == spt_pkg::ID_NONE) ? '0 : amp_neg;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain_ctl[TIME_BITS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      stim_q <= stim_d;
      id_q   <= id_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = spt_pkg::OUT_TDATA_W'({id_q, stim_q});

  `SPT_ASSERT(a_id_known, out_vld_q |-> (id_q == spt_pkg::ID_NONE || id_q == spt_pkg::ID_S1 || id_q == spt_pkg::ID_S2), "train code out of range")
  `SPT_ASSERT(a_idle_zero, (out_vld_q && id_q == spt_pkg::ID_NONE) |-> (stim_q == '0), "stimulus without a pulse")
  `SPT_ASSERT(a_no_min_amp, (out_vld_q && id_q != spt_pkg::ID_NONE) |-> (stim_q != spt_pkg::AMP_MIN), "negation not saturated")

endmodule

@@ tb/sv/s1_s2_stimulus_pulse_train_test.sv @@
// testbench of the S1/S2 pacing stimulus generator with its own pulse predictor
`timescale 1ns / 100ps

module s1_s2_stimulus_pulse_train_test;

  // index past the register list, writes to it are dropped
  localparam spt_pkg::cfg_idx_t REG_UNUSED = 3'd7;
  localparam logic [23:0] PER_MAX = 24'hff_ffff;
  localparam logic [15:0] CNT_MAX = 16'hffff;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic signed [spt_pkg::AMP_W-1:0] stim;
    spt_pkg::train_id_t               id;
  } pulse_t;

  typedef struct {
    logic [31:0]                      start;
    logic [23:0]                      p1;
    logic [15:0]                      c1;
    logic [23:0]                      p2;
    logic [15:0]                      c2;
    logic [23:0]                      width;
    logic signed [spt_pkg::AMP_W-1:0] amp;
  } train_cfg_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic [31:0]                     s_axis_tdata_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [spt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  spt_pkg::cfg_idx_t               cfg_addr_i = spt_pkg::REG_START_TIME;
  logic [spt_pkg::CFG_DW-1:0]      cfg_data_i = '0;

  train_cfg_t  train_cfg = '{default: '0};
  idle_mode_e  idle_mode = IDLE_NONE;
  logic [31:0] pending_times[$];
  pulse_t      expected_pulses[$];
  int unsigned mismatch_cnt = 0;

  s1_s2_stimulus_pulse_train u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // true when tick t lands on a pulse of a train starting at base
  function automatic bit train_hits(longint unsigned t, longint unsigned base,
                                    longint unsigned period, longint unsigned count);
    longint unsigned since;
    if (period == 0 || count == 0 || t < base) return 1'b0;
    since = t - base;
    if (since > period * count) return 1'b0;
    return (since % period) <= longint'(train_cfg.width);
  endfunction

  // stimulus and train at one time stamp
  function automatic pulse_t pulse_at(logic [31:0] t);
    longint unsigned base1;
    longint unsigned base2;
    int              level;
    pulse_t          p;
    base1 = train_cfg.start;
    base2 = base1 + longint'(train_cfg.p1) * longint'(train_cfg.c1);
    p.id = spt_pkg::ID_NONE;
    if (train_hits(t, base1, train_cfg.p1, train_cfg.c1)) p.id = spt_pkg::ID_S1;
    else if (train_hits(t, base2, train_cfg.p2, train_cfg.c2)) p.id = spt_pkg::ID_S2;
    level = 0;
    if (p.id != spt_pkg::ID_NONE) begin
      level = -int'(train_cfg.amp);
      if (level > 32767) level = 32767;
    end
    p.stim = level[15:0];
    return p;
  endfunction

  function automatic bit send_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 71;
      IDLE_BOTH: return $urandom_range(99) < 20;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (idle_mode)
      IDLE_RECV: return $urandom_range(99) < 71;
      IDLE_BOTH: return $urandom_range(99) < 20;
      default:   return 1'b0;
    endcase
  endfunction

  // time stamps biased to the spans, their boundaries and pulse edges
  function automatic logic [31:0] pick_time();
    longint unsigned base;
    longint unsigned span1;
    longint unsigned span2;
    longint unsigned t;
    int unsigned     roll;
    base  = train_cfg.start;
    span1 = longint'(train_cfg.p1) * longint'(train_cfg.c1);
    span2 = longint'(train_cfg.p2) * longint'(train_cfg.c2);
    roll  = $urandom_range(99);
    if (roll < 15) begin
      t = $urandom;
    end else if (roll < 40) begin
      case ($urandom_range(3))
        0: t = base + span1;
        1: t = base + span1 + span2;
        2: t = base + longint'(train_cfg.p1) * $urandom_range(train_cfg.c1)
               + train_cfg.width;
        default: t = base + span1 + longint'(train_cfg.p2) * $urandom_range(train_cfg.c2)
                     + train_cfg.width;
      endcase
      t = t + $urandom_range(4) - 2;
    end else begin
      t = base + (longint'({$urandom, $urandom}) % (span1 + span2 + 8)) - 4;
    end
    return t[31:0];
  endfunction

  // input driver: one beat per handshake, fed from the pending time stamps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) expected_pulses.push_back(pulse_at(s_axis_tdata_i));
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_times.size() != 0 && !send_gap()) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_times.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // output monitor: compare each result beat with the oldest expected pulse
  always @(posedge clk_i or negedge rst_ni) begin
    pulse_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_pulses.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected result beat, expected none, actual stimulus %0d train %0d",
                   $time, $signed(m_axis_tdata_o[15:0]), m_axis_tdata_o[17:16]);
        end else begin
          want = expected_pulses.pop_front();
          if (m_axis_tdata_o[15:0] !== want.stim || m_axis_tdata_o[17:16] !== want.id) begin
            mismatch_cnt++;
            $display("%0t: expected stimulus %0d train %0d, actual stimulus %0d train %0d",
                     $time, want.stim, want.id, $signed(m_axis_tdata_o[15:0]),
                     m_axis_tdata_o[17:16]);
          end
        end
      end
      m_axis_tready_i <= !recv_stall();
    end
  end

  // one register write, called at a rising edge, leaves cfg_valid_i high
  task automatic write_reg(spt_pkg::cfg_idx_t idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      spt_pkg::REG_START_TIME:  train_cfg.start = value;
      spt_pkg::REG_S1_PERIOD:   train_cfg.p1    = value[23:0];
      spt_pkg::REG_S1_COUNT:    train_cfg.c1    = value[15:0];
      spt_pkg::REG_S2_PERIOD:   train_cfg.p2    = value[23:0];
      spt_pkg::REG_S2_COUNT:    train_cfg.c2    = value[15:0];
      spt_pkg::REG_PULSE_WIDTH: train_cfg.width = value[23:0];
      spt_pkg::REG_AMPLITUDE:   train_cfg.amp   = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_trains(logic [31:0] start, logic [23:0] p1, logic [15:0] c1,
                            logic [23:0] p2, logic [15:0] c2, logic [23:0] width,
                            logic [15:0] amp);
    write_reg(spt_pkg::REG_START_TIME, start);
    write_reg(spt_pkg::REG_S1_PERIOD, {8'($urandom_range(255)), p1});
    write_reg(spt_pkg::REG_S1_COUNT, {16'($urandom_range(65535)), c1});
    write_reg(spt_pkg::REG_S2_PERIOD, {8'($urandom_range(255)), p2});
    write_reg(spt_pkg::REG_S2_COUNT, {16'($urandom_range(65535)), c2});
    write_reg(spt_pkg::REG_PULSE_WIDTH, {8'($urandom_range(255)), width});
    write_reg(spt_pkg::REG_AMPLITUDE, {16'($urandom_range(65535)), amp});
    write_reg(REG_UNUSED, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  // hold off until every expected pulse is in, then let the pipeline settle
  task automatic drain();
    wait (pending_times.size() == 0 && !s_axis_tvalid_i && expected_pulses.size() == 0);
    repeat (45) @(posedge clk_i);
  endtask

  function automatic logic [23:0] pick_period();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 18) return PER_MAX;
    return 24'($urandom_range(1, 40));
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 15) return CNT_MAX;
    return 16'($urandom_range(1, 6));
  endfunction

  task automatic random_trains();
    logic [31:0] start;
    logic [23:0] width;
    logic [15:0] amp;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) start = $urandom_range(500);
    else if (roll < 80) start = $urandom;
    else start = 32'hffff_ff00 + $urandom_range(255);
    roll = $urandom_range(99);
    if (roll < 10) width = '0;
    else if (roll < 18) width = PER_MAX;
    else width = 24'($urandom_range(45));
    roll = $urandom_range(99);
    if (roll < 10) amp = spt_pkg::AMP_MIN;
    else if (roll < 18) amp = '0;
    else if (roll < 25) amp = spt_pkg::AMP_MAX;
    else amp = 16'($urandom);
    set_trains(start, pick_period(), pick_count(), pick_period(), pick_count(), width, amp);
  endtask

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // S1 of 3 x 10 from tick 100, S2 of 2 x 7 right after, width 2
    set_trains(32'd100, 24'd10, 16'd3, 24'd7, 16'd2, 24'd2, 16'd1000);
    pending_times = '{32'd0, 32'd99, 32'd100, 32'd102, 32'd103, 32'd130, 32'd131,
                      32'd132, 32'd133, 32'd137, 32'd144, 32'd145, 32'hffff_ffff};
    drain();
    // most negative amplitude saturates
    set_trains(32'd100, 24'd10, 16'd3, 24'd7, 16'd2, 24'd2, spt_pkg::AMP_MIN);
    pending_times = '{32'd101, 32'd131};
    drain();
    // zero amplitude still reports the train
    set_trains(32'd100, 24'd10, 16'd3, 24'd7, 16'd2, 24'd2, 16'd0);
    pending_times = '{32'd100, 32'd138};
    drain();
    // S1 disabled: S2 starts at the start time
    set_trains(32'd50, 24'd0, 16'd4, 24'd5, 16'd2, 24'd1, spt_pkg::AMP_MAX);
    pending_times = '{32'd49, 32'd50, 32'd52, 32'd60, 32'd61};
    drain();
    // largest registers and start at the top of time
    set_trains(32'hffff_ffff, PER_MAX, CNT_MAX, PER_MAX, CNT_MAX, PER_MAX, 16'h0001);
    pending_times = '{32'hffff_ffff, 32'd0, 32'hffff_fffe};
    drain();

    // random phases cycling through the idling mixes
    for (int ph = 0; ph < 12; ph++) begin
      idle_mode = idle_mode_e'(ph % 4);
      random_trains();
      for (int i = 0; i < 100; i++) begin
        pending_times.push_back(pick_time());
        if (ph == 5 && i == 49) drain();
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
